// ===== rtl/core/asp_pkg.sv =====
// asp_pkg: shared types and constants of the atlas shelf packer
// used by atlas_shelf_packer and asp_port_checks; no dependencies
`default_nettype none

package asp_pkg;

    // fixed field widths
    localparam int RECT_W     = 16;
    localparam int SIZE_W     = 17;
    localparam int OUT_W      = 22;
    localparam int GROW_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_W    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_H    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GROWS = 2'd2;

    // register values after reset
    localparam logic [SIZE_W-1:0] INIT_W_RST    = 17'd8192;
    localparam logic [SIZE_W-1:0] INIT_H_RST    = 17'd4096;
    localparam logic [GROW_W-1:0] MAX_GROWS_RST = 4'd10;

    // commands
    localparam logic CMD_PLACE   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RESTART  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC_X,
        ST_CALC_Y,
        ST_SHELF,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/asp_alu.sv =====
// asp_alu: the shared add and compare unit of the shelf packer
// sums two coordinates and checks the sum against a limit; no dependencies
`default_nettype none

module asp_alu #(
    parameter int W = 23
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_lim,
    output logic      [W-1:0] o_sum,
    output logic              o_le
);

    // operands are zero-extended by the caller so the sum never wraps
    assign o_sum = i_a + i_b;
    assign o_le  = (o_sum <= i_lim);

endmodule

`default_nettype wire

// ===== rtl/core/atlas_shelf_packer.sv =====
// Shelf packer for rectangles in a texture atlas: a place command takes one
// input transfer and gives one result transfer. A rectangle that fits at the
// cursor goes through accept, x compare, y compare and result. Each move to
// the next shelf adds a shelf step and a new x and y compare, and each atlas
// growth adds a new x and y compare, all of it set by the single add and
// compare unit that serves every pass of the placement loop. A restart goes
// from accept straight to the result. The input is stalled from accept until
// the result is transferred. Depends on asp_pkg and asp_alu.
`default_nettype none

module atlas_shelf_packer #(
    parameter int COORD_BITS = 22
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [asp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [asp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_command,
    input  wire logic [asp_pkg::RECT_W-1:0]         i_rect_width,
    input  wire logic [asp_pkg::RECT_W-1:0]         i_rect_height,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [asp_pkg::OUT_W-1:0]          o_offset_x,
    output logic      [asp_pkg::OUT_W-1:0]          o_offset_y,
    output logic      [asp_pkg::OUT_W-1:0]          o_width_now,
    output logic      [asp_pkg::OUT_W-1:0]          o_height_now,
    output logic      [asp_pkg::STATUS_W-1:0]       o_status
);

    localparam int C     = COORD_BITS;
    localparam int SW    = asp_pkg::SIZE_W;
    localparam int GW    = asp_pkg::GROW_W;
    localparam int SUM_W = ((C > SW) ? C : SW) + 1;
    localparam logic [63:0] CMAX = (64'd1 << C) - 64'd1;

    // initial size: zero taken as one, saturated to the coordinate range
    function automatic logic [C-1:0] f_init_size(input logic [SW-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        if (t == 64'd0) t = 64'd1;
        if (t > CMAX) t = CMAX;
        return t[C-1:0];
    endfunction

    // coordinate to output field width
    function automatic logic [asp_pkg::OUT_W-1:0] f_out(input logic [C-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[asp_pkg::OUT_W-1:0];
    endfunction

    // configuration registers
    logic [SW-1:0]          r_init_w, r_init_h;
    logic [GW-1:0]          r_max_grows;

    // committed layout
    logic [C-1:0]           r_c_cur_x, r_c_cur_y, r_c_row, r_c_atl_w, r_c_atl_h;
    logic [SW-1:0]          r_c_shelf;
    logic [GW-1:0]          r_c_grows;
    logic [C-1:0]           n_c_cur_x, n_c_cur_y, n_c_row, n_c_atl_w, n_c_atl_h;
    logic [SW-1:0]          n_c_shelf;
    logic [GW-1:0]          n_c_grows;

    // working copy for the item in flight
    logic [C-1:0]           r_w_cur_x, r_w_cur_y, r_w_row, r_w_atl_w, r_w_atl_h;
    logic [SW-1:0]          r_w_shelf;
    logic [GW-1:0]          r_w_grows;
    logic [C-1:0]           n_w_cur_x, n_w_cur_y, n_w_row, n_w_atl_w, n_w_atl_h;
    logic [SW-1:0]          n_w_shelf;
    logic [GW-1:0]          n_w_grows;

    // padded rectangle, x pass result and output payload
    logic [SW-1:0]          r_w1, r_h1, n_w1, n_h1;
    logic [C-1:0]           r_mx, n_mx;
    logic                   r_fit_x, n_fit_x;
    logic [C-1:0]           r_ox, r_oy, n_ox, n_oy;
    logic [asp_pkg::STATUS_W-1:0] r_status, n_status;

    asp_pkg::t_state        r_state, n_state;

    // shared unit operands
    logic [SUM_W-1:0]       alu_a, alu_b, alu_lim, alu_sum;
    logic                   alu_le;
    logic                   grow_ok;

    asp_alu #(.W(SUM_W)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_lim (alu_lim),
        .o_sum (alu_sum),
        .o_le  (alu_le)
    );

    // operand selection by sequencer step
    always_comb begin
        case (r_state)
            asp_pkg::ST_CALC_X: begin
                alu_a   = SUM_W'(r_w_cur_x);
                alu_b   = SUM_W'(r_w1);
                alu_lim = SUM_W'(r_w_atl_w);
            end
            asp_pkg::ST_CALC_Y: begin
                alu_a   = SUM_W'(r_w_cur_y);
                alu_b   = SUM_W'(r_h1);
                alu_lim = SUM_W'(r_w_atl_h);
            end
            asp_pkg::ST_SHELF: begin
                alu_a   = SUM_W'(r_w_cur_y);
                alu_b   = SUM_W'(r_w_shelf);
                alu_lim = SUM_W'(r_w_atl_h);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_lim = '0;
            end
        endcase
    end

    // growth allowed: under the limit and the doubled side still in range
    assign grow_ok = (r_w_grows < r_max_grows) &&
                     (r_w_grows[0] ? !r_w_atl_h[C-1] : !r_w_atl_w[C-1]);

    // sequencer: next state and next values
    always_comb begin
        n_state   = r_state;
        n_c_cur_x = r_c_cur_x;
        n_c_cur_y = r_c_cur_y;
        n_c_row   = r_c_row;
        n_c_atl_w = r_c_atl_w;
        n_c_atl_h = r_c_atl_h;
        n_c_shelf = r_c_shelf;
        n_c_grows = r_c_grows;
        n_w_cur_x = r_w_cur_x;
        n_w_cur_y = r_w_cur_y;
        n_w_row   = r_w_row;
        n_w_atl_w = r_w_atl_w;
        n_w_atl_h = r_w_atl_h;
        n_w_shelf = r_w_shelf;
        n_w_grows = r_w_grows;
        n_w1      = r_w1;
        n_h1      = r_h1;
        n_mx      = r_mx;
        n_fit_x   = r_fit_x;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_status  = r_status;
        case (r_state)
            asp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_command == asp_pkg::CMD_RESTART) begin
                        n_c_cur_x = '0;
                        n_c_cur_y = '0;
                        n_c_row   = '0;
                        n_c_shelf = '0;
                        n_c_grows = '0;
                        n_c_atl_w = f_init_size(r_init_w);
                        n_c_atl_h = f_init_size(r_init_h);
                        n_ox      = '0;
                        n_oy      = '0;
                        n_status  = asp_pkg::STAT_RESTART;
                        n_state   = asp_pkg::ST_OUT;
                    end else begin
                        n_w_cur_x = r_c_cur_x;
                        n_w_cur_y = r_c_cur_y;
                        n_w_row   = r_c_row;
                        n_w_atl_w = r_c_atl_w;
                        n_w_atl_h = r_c_atl_h;
                        n_w_shelf = r_c_shelf;
                        n_w_grows = r_c_grows;
                        n_w1      = SW'(i_rect_width) + SW'(1);
                        n_h1      = SW'(i_rect_height) + SW'(1);
                        n_state   = asp_pkg::ST_CALC_X;
                    end
                end
            end
            asp_pkg::ST_CALC_X: begin
                n_mx    = alu_sum[C-1:0];
                n_fit_x = alu_le;
                n_state = asp_pkg::ST_CALC_Y;
            end
            asp_pkg::ST_CALC_Y: begin
                if (r_fit_x && alu_le) begin
                    // fits at the cursor: commit the working layout
                    n_c_cur_x = r_mx;
                    n_c_cur_y = r_w_cur_y;
                    n_c_row   = r_w_row;
                    n_c_atl_w = r_w_atl_w;
                    n_c_atl_h = r_w_atl_h;
                    n_c_shelf = (r_h1 > r_w_shelf) ? r_h1 : r_w_shelf;
                    n_c_grows = r_w_grows;
                    n_ox      = r_w_cur_x;
                    n_oy      = r_w_cur_y;
                    n_status  = asp_pkg::STAT_PLACED;
                    n_state   = asp_pkg::ST_OUT;
                end else if (!alu_le || (r_w_cur_x == r_w_row)) begin
                    if (grow_ok) begin
                        // odd growth widens, even growth heightens
                        if (!r_w_grows[0]) begin
                            n_w_row   = r_w_atl_w;
                            n_w_cur_x = r_w_atl_w;
                            n_w_cur_y = '0;
                            n_w_atl_w = {r_w_atl_w[C-2:0], 1'b0};
                        end else begin
                            n_w_row   = '0;
                            n_w_cur_x = '0;
                            n_w_cur_y = r_w_atl_h;
                            n_w_atl_h = {r_w_atl_h[C-2:0], 1'b0};
                        end
                        n_w_shelf = '0;
                        n_w_grows = r_w_grows + GW'(1);
                        n_state   = asp_pkg::ST_CALC_X;
                    end else begin
                        // overflow: committed layout stays as it was
                        n_ox     = '0;
                        n_oy     = '0;
                        n_status = asp_pkg::STAT_OVERFLOW;
                        n_state  = asp_pkg::ST_OUT;
                    end
                end else begin
                    n_state = asp_pkg::ST_SHELF;
                end
            end
            asp_pkg::ST_SHELF: begin
                // next shelf starts below the current one
                n_w_cur_y = alu_sum[C-1:0];
                n_w_cur_x = r_w_row;
                n_w_shelf = '0;
                n_state   = asp_pkg::ST_CALC_X;
            end
            asp_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = asp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = asp_pkg::ST_IDLE;
            end
        endcase
    end

    // control state, committed layout and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asp_pkg::ST_IDLE;
            r_init_w    <= asp_pkg::INIT_W_RST;
            r_init_h    <= asp_pkg::INIT_H_RST;
            r_max_grows <= asp_pkg::MAX_GROWS_RST;
            r_c_cur_x   <= '0;
            r_c_cur_y   <= '0;
            r_c_row     <= '0;
            r_c_shelf   <= '0;
            r_c_grows   <= '0;
            r_c_atl_w   <= f_init_size(asp_pkg::INIT_W_RST);
            r_c_atl_h   <= f_init_size(asp_pkg::INIT_H_RST);
        end else begin
            r_state   <= n_state;
            r_c_cur_x <= n_c_cur_x;
            r_c_cur_y <= n_c_cur_y;
            r_c_row   <= n_c_row;
            r_c_shelf <= n_c_shelf;
            r_c_grows <= n_c_grows;
            r_c_atl_w <= n_c_atl_w;
            r_c_atl_h <= n_c_atl_h;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    asp_pkg::CFG_INIT_W:    r_init_w    <= i_cfg_data;
                    asp_pkg::CFG_INIT_H:    r_init_h    <= i_cfg_data;
                    asp_pkg::CFG_MAX_GROWS: r_max_grows <= i_cfg_data[GW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // working copy and result payload
    always_ff @(posedge i_clk) begin
        r_w_cur_x <= n_w_cur_x;
        r_w_cur_y <= n_w_cur_y;
        r_w_row   <= n_w_row;
        r_w_atl_w <= n_w_atl_w;
        r_w_atl_h <= n_w_atl_h;
        r_w_shelf <= n_w_shelf;
        r_w_grows <= n_w_grows;
        r_w1      <= n_w1;
        r_h1      <= n_h1;
        r_mx      <= n_mx;
        r_fit_x   <= n_fit_x;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_status  <= n_status;
    end

    // handshake and result fields
    assign o_stall      = (r_state != asp_pkg::ST_IDLE);
    assign o_valid      = (r_state == asp_pkg::ST_OUT);
    assign o_offset_x   = f_out(r_ox);
    assign o_offset_y   = f_out(r_oy);
    assign o_width_now  = f_out(r_c_atl_w);
    assign o_height_now = f_out(r_c_atl_h);
    assign o_status     = r_status;

endmodule

`default_nettype wire

// ===== rtl/core/asp_checker.sv =====
// asp_port_checks: port-level assertions for the atlas shelf packer
// depends on asp_pkg; bound to atlas_shelf_packer at the end of this file
`default_nettype none

module asp_port_checks (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_stall,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic [asp_pkg::OUT_W-1:0]          o_offset_x,
    input wire logic [asp_pkg::OUT_W-1:0]          o_offset_y,
    input wire logic [asp_pkg::OUT_W-1:0]          o_width_now,
    input wire logic [asp_pkg::OUT_W-1:0]          o_height_now,
    input wire logic [asp_pkg::STATUS_W-1:0]       o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_offset_x) && $stable(o_offset_y)
            && $stable(o_width_now) && $stable(o_height_now) && $stable(o_status))
        else $error("result changed while stalled");

    // no new item is taken while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while result pending");

    // exactly one result transfer per item
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result repeated after transfer");

    // restart and overflow report a zero offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == asp_pkg::STAT_RESTART || o_status == asp_pkg::STAT_OVERFLOW)
            |-> o_offset_x == '0 && o_offset_y == '0)
        else $error("nonzero offset on unplaced result");

endmodule

bind atlas_shelf_packer asp_port_checks u_asp_port_checks (.*);

`default_nettype wire
